// ===== hdl/cale_pkg.sv =====
package cale_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // Field widths of the request and response words
  localparam int KIND_W   = 4;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 2;

  // Cells per readout group; two group levels cover the whole capacity range
  localparam int GROUP_SIZE = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND   = 4'd0,
    KIND_INSERT   = 4'd1,
    KIND_REMOVE   = 4'd2,
    KIND_NEXT     = 4'd3,
    KIND_PREV     = 4'd4,
    KIND_START    = 4'd5,
    KIND_END      = 4'd6,
    KIND_POSITION = 4'd7,
    KIND_CLEAR    = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_ENTRY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_FINAL
  } state_t;

endpackage

// ===== hdl/cale_if.sv =====
interface cale_in_if;
  import cale_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] data_value;
  logic [POS_W-1:0]  position;

  modport source (output valid, kind, data_value, position, input ready);
  modport sink   (input valid, kind, data_value, position, output ready);
endinterface

interface cale_out_if;
  import cale_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    length;
  logic [POS_W-1:0]    cursor;
  logic [DATA_W-1:0]   current_value;
  logic                value_valid;

  modport source (output valid, status, length, cursor, current_value, value_valid,
                  input ready);
  modport sink   (input valid, status, length, cursor, current_value, value_valid,
                  output ready);
endinterface

// ===== hdl/cale_cell.sv =====
module cale_cell #(
  parameter int DW  = cale_pkg::DATA_WIDTH_DEF,
  parameter int CW  = $clog2(cale_pkg::CAPACITY_DEF + 1),
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cale_pkg::cell_op_t op,
  input  logic [CW-1:0]      count,
  input  logic [CW-1:0]      cursor,
  input  logic [DW-1:0]      data,
  input  logic [DW-1:0]      lower,
  input  logic [DW-1:0]      upper,
  output logic [DW-1:0]      value
);
  import cale_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [DW-1:0] value_next;

  always_comb begin
    value_next = value;
    case (op)
      CELL_APPEND: begin
        if (MY_IDX == count) value_next = data;
      end
      CELL_INSERT: begin
        if (MY_IDX == cursor)     value_next = data;
        else if (MY_IDX > cursor) value_next = lower;
      end
      CELL_REMOVE: begin
        if (MY_IDX >= cursor) value_next = upper;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== hdl/cale_group.sv =====
module cale_group #(
  parameter int GS   = cale_pkg::GROUP_SIZE,
  parameter int DW   = cale_pkg::DATA_WIDTH_DEF,
  parameter int CW   = $clog2(cale_pkg::CAPACITY_DEF + 1),
  parameter int BASE = 0
) (
  input  logic          clk,
  input  logic [DW-1:0] vals [GS],
  input  logic [CW-1:0] cursor,
  output logic [DW-1:0] sel
);
  import cale_pkg::*;

  logic [DW-1:0] sel_next;

  // padding members are tied to zero, so index aliasing there is harmless
  always_comb begin
    sel_next = '0;
    for (int j = 0; j < GS; j++) begin
      if (CW'(BASE + j) == cursor) sel_next = sel_next | vals[j];
    end
  end

  always_ff @(posedge clk) begin
    sel <= sel_next;
  end

endmodule

// ===== hdl/cursor_array_list_engine_core.sv =====
// Ordered list of up to CAPACITY elements with a cursor, one response word per
// request word. A request is taken in the idle state: the cell row, length and
// cursor update on the accepting edge, the cursor's element is picked in groups
// of 64 cells on the next edge, and the groups are merged into the output
// register once that register is free, so a stalled output holds the sequencer.
// No new request is taken until its response is loaded into the output register;
// the two-level readout of the cell row sets this pace. Element storage needs no
// clearing after reset; only length, cursor, state and output valid are reset.
module cursor_array_list_engine_core #(
  parameter int CAPACITY   = cale_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = cale_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  cale_in_if.sink   req,
  cale_out_if.source rsp
);
  import cale_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int NG   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] cursor, cursor_next;
  status_t       status, status_next;
  cell_op_t      op, cell_op;
  logic          accept;
  logic          out_valid;
  logic          load_out;

  logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
  logic [DATA_WIDTH-1:0] grp_in   [NG][GROUP_SIZE];
  logic [DATA_WIDTH-1:0] grp_sel  [NG];
  logic [DATA_WIDTH-1:0] merged;
  logic [DATA_WIDTH-1:0] data_in;

  assign accept    = req.valid && req.ready;
  assign data_in   = DATA_WIDTH'(req.data_value);
  assign cell_op   = accept ? op : CELL_HOLD;
  assign rsp.valid = out_valid;

  // list control: decode the request against the current length and cursor
  always_comb begin
    op          = CELL_HOLD;
    count_next  = count;
    cursor_next = cursor;
    status_next = STATUS_OK;
    case (req.kind)
      KIND_APPEND: begin
        if (count == CAP_C) status_next = STATUS_FULL;
        else begin
          op         = CELL_APPEND;
          count_next = count + 1'b1;
        end
      end
      KIND_INSERT: begin
        if (count == CAP_C) status_next = STATUS_FULL;
        else begin
          op         = CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (cursor >= count) status_next = STATUS_NO_ENTRY;
        else begin
          op         = CELL_REMOVE;
          count_next = count - 1'b1;
        end
      end
      KIND_NEXT: begin
        if (cursor < count) cursor_next = cursor + 1'b1;
      end
      KIND_PREV: begin
        if (cursor != '0) cursor_next = cursor - 1'b1;
      end
      KIND_START: cursor_next = '0;
      KIND_END:   cursor_next = count;
      KIND_POSITION: begin
        if (CMPW'(req.position) > CMPW'(count)) status_next = STATUS_NO_ENTRY;
        else cursor_next = CW'(req.position);
      end
      KIND_CLEAR: begin
        count_next  = '0;
        cursor_next = '0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) state_next = ST_GROUP;
      end
      ST_GROUP: state_next = ST_FINAL;
      ST_FINAL: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) status <= status_next;
  end

  // cell row: each cell sees its two neighbours; the ends see themselves
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;
    if (i == 0) begin : g_lo_end
      assign lower = cell_val[i];
    end else begin : g_lo
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_end
      assign upper = cell_val[i];
    end else begin : g_hi
      assign upper = cell_val[i+1];
    end
    cale_cell #(.DW(DATA_WIDTH), .CW(CW), .IDX(i)) u_cell (
      .clk    (clk),
      .op     (cell_op),
      .count  (count),
      .cursor (cursor),
      .data   (data_in),
      .lower  (lower),
      .upper  (upper),
      .value  (cell_val[i])
    );
  end

  // readout groups
  for (genvar g = 0; g < NG; g++) begin : g_grp
    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_member
      if (g * GROUP_SIZE + j < CAPACITY) begin : g_real
        assign grp_in[g][j] = cell_val[g * GROUP_SIZE + j];
      end else begin : g_pad
        assign grp_in[g][j] = '0;
      end
    end
    cale_group #(.GS(GROUP_SIZE), .DW(DATA_WIDTH), .CW(CW), .BASE(g * GROUP_SIZE)) u_grp (
      .clk    (clk),
      .vals   (grp_in[g]),
      .cursor (cursor),
      .sel    (grp_sel[g])
    );
  end

  always_comb begin
    merged = '0;
    for (int g = 0; g < NG; g++) merged = merged | grp_sel[g];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status        <= status;
      rsp.length        <= POS_W'(count);
      rsp.cursor        <= POS_W'(cursor);
      rsp.value_valid   <= cursor < count;
      rsp.current_value <= (cursor < count) ? DATA_W'(merged) : '0;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor beyond list length");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("list length beyond capacity");

  a_accept_starts_readout: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_GROUP) ##1 (state == ST_FINAL))
    else $error("readout sequence broken after accepted word");

  a_no_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.value_valid) |-> (rsp.current_value == '0))
    else $error("current value not zero without current element");

endmodule
